>>> hdl/ccp_pkg.sv
// Package: shared types, constants and name tables of the Cache-Control parser.
package ccp_pkg;

   localparam int NumNames   = 16;
   localparam int NumFlags   = 10;
   localparam int NumDeltas  = 6;
   localparam int MaxStaleIx = 14;
   localparam int NameLenMax = 24;
   localparam logic [30:0] DeltaMax = 31'h7FFF_FFFF;
   localparam logic [31:0] DeltaAbsent = 32'hFFFF_FFFF;
   localparam logic [31:0] DeltaNoValue = 32'hFFFF_FFFE;

   typedef enum logic [2:0] {
      PH_SKIP  = 3'b001,
      PH_NAME  = 3'b010,
      PH_VALUE = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [9:0]  flag_bits;
      logic [31:0] max_age_secs;
      logic [31:0] shared_max_age_secs;
      logic [31:0] stale_revalidate_secs;
      logic [31:0] stale_error_secs;
      logic [31:0] max_stale_secs;
      logic [31:0] min_fresh_secs;
      logic        any_known;
   } rsp_type;

   // Directive lengths, in table order.
   function automatic logic [4:0] dir_len(input int k);
      logic [4:0] l;
      unique case (k)
         0: l = 5'd6;    1: l = 5'd7;    2: l = 5'd8;    3: l = 5'd8;
         4: l = 5'd12;   5: l = 5'd15;   6: l = 5'd16;   7: l = 5'd15;
         8: l = 5'd9;    9: l = 5'd14;  10: l = 5'd7;   11: l = 5'd8;
         12: l = 5'd22; 13: l = 5'd14;  14: l = 5'd9;   15: l = 5'd9;
         default: l = 5'd0;
      endcase
      return l;
   endfunction

   // Directive text, first character in the top byte.
   function automatic logic [8*NameLenMax-1:0] dir_text(input int k);
      logic [8*NameLenMax-1:0] t;
      unique case (k)
         0:  t = {"public",                 {18{8'h00}}};
         1:  t = {"private",                {17{8'h00}}};
         2:  t = {"no-store",               {16{8'h00}}};
         3:  t = {"no-cache",               {16{8'h00}}};
         4:  t = {"no-transform",           {12{8'h00}}};
         5:  t = {"must-revalidate",        {9{8'h00}}};
         6:  t = {"proxy-revalidate",       {8{8'h00}}};
         7:  t = {"must-understand",        {9{8'h00}}};
         8:  t = {"immutable",              {15{8'h00}}};
         9:  t = {"only-if-cached",         {10{8'h00}}};
         10: t = {"max-age",                {17{8'h00}}};
         11: t = {"s-maxage",               {16{8'h00}}};
         12: t = {"stale-while-revalidate", {2{8'h00}}};
         13: t = {"stale-if-error",         {10{8'h00}}};
         14: t = {"max-stale",              {15{8'h00}}};
         default: t = {"min-fresh",         {15{8'h00}}};
      endcase
      return t;
   endfunction

endpackage

>>> hdl/ccp_stream_if.sv
// Interface: valid/ready channel carrying one payload.
interface ccp_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/ccp_name_match.sv
// Name matcher: knocks out directive candidates for one name character.
module ccp_name_match
   import ccp_pkg::*;
(
   input  logic [7:0]          char_in,
   input  logic [4:0]          position,
   input  logic [NumNames-1:0] cand_in,
   output logic [NumNames-1:0] cand_out
);
   logic [7:0] lower;
   logic [8*NameLenMax-1:0] text;
   logic [7:0] expect_ch;

   // Fold upper case letters, then compare against each directive's character.
   always_comb begin
      lower = (char_in >= 8'h41 && char_in <= 8'h5A) ? char_in + 8'd32 : char_in;
      cand_out = cand_in;
      text = '0;
      expect_ch = '0;
      for (int k = 0; k < NumNames; k++) begin
         text = dir_text(k);
         expect_ch = (position < 5'(NameLenMax))
            ? text[8*NameLenMax-1 - 8*position -: 8] : 8'h00;
         if (position >= dir_len(k) || expect_ch != lower) begin
            cand_out[k] = 1'b0;
         end
      end
   end
endmodule

>>> hdl/cache_control_header_parser.sv
// Top level: Cache-Control header parser, one byte per transfer.
//
//  Channel | Prefix | Dir | Payload
//  req     | req_   | in  | header_byte, byte_present, last_byte
//  rsp     | rsp_   | out | flags, six delta values, any_known
//
// One byte is taken per cycle unless stalled; parse state updates in that cycle.
// A header's result is in the output register the cycle after its last byte.
// The input stalls only when the output register is full and not being taken.
// Synchronous active-high reset returns all parse state to its initial value.
module cache_control_header_parser
   import ccp_pkg::*;
(
   input logic clock,
   input logic reset,
   ccp_stream_if.sink   req_chan,
   ccp_stream_if.source rsp_chan
);
   phase_type phase_ff, phase_in;
   logic [NumNames-1:0] cand_ff, cand_in, cand_match;
   logic [4:0] pos_ff, pos_in;
   logic closed_ff, closed_in, eq_ff, eq_in;
   logic [30:0] acc_ff, acc_in;
   logic dseen_ff, dseen_in, dend_ff, dend_in;
   logic [NumFlags-1:0] flags_ff, flags_in;
   logic [31:0] delta_ff [NumDeltas], delta_in [NumDeltas];
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   req_type req;
   logic take, ows, is_digit, is_comma, commit;
   logic [34:0] prod;
   logic [NumFlags-1:0] cf;
   logic [31:0] cd [NumDeltas];
   logic cfound, hit;

   assign req = req_chan.payload;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = req_chan.valid && req_chan.ready;
   assign ows = req.header_byte == 8'h20 || req.header_byte == 8'h09;
   assign is_digit = req.header_byte >= 8'h30 && req.header_byte <= 8'h39;
   assign is_comma = req.byte_present && req.header_byte == 8'h2C;
   assign prod = {4'd0, acc_ff} * 35'd10 + {27'd0, req.header_byte - 8'h30};

   ccp_name_match u_match (
      .char_in (req.header_byte),
      .position(pos_ff),
      .cand_in (cand_ff),
      .cand_out(cand_match)
   );

   // Per-byte segment update and commit.
   always_comb begin
      phase_in = phase_ff; cand_in = cand_ff; pos_in = pos_ff;
      closed_in = closed_ff; eq_in = eq_ff; acc_in = acc_ff;
      dseen_in = dseen_ff; dend_in = dend_ff;
      commit = 1'b0;
      if (req.byte_present) begin
         if (req.header_byte == 8'h2C) begin
            // Close the segment; its state is committed below before it clears.
            commit = phase_ff != PH_SKIP;
            phase_in = PH_SKIP;
         end else if ((phase_ff == PH_SKIP && !ows) || phase_ff == PH_NAME) begin
            phase_in = PH_NAME;
            if (req.header_byte == 8'h3D) begin
               eq_in = 1'b1;
               phase_in = PH_VALUE;
            end else if (ows) begin
               closed_in = 1'b1;
            end else if (closed_ff) begin
               cand_in = '0;
            end else begin
               cand_in = cand_match;
               if (pos_ff != 5'd31) pos_in = pos_ff + 5'd1;
            end
         end else if (phase_ff == PH_VALUE && !dend_ff) begin
            if (is_digit) begin
               acc_in = (prod > {4'd0, DeltaMax}) ? DeltaMax : prod[30:0];
               dseen_in = 1'b1;
            end else if (!(!dseen_ff && (ows || req.header_byte == 8'h22))) begin
               dend_in = 1'b1;
            end
         end
      end
      if (req.last_byte && phase_in != PH_SKIP) commit = 1'b1;

      // Commit the segment: first candidate whose length matches wins.
      cf = flags_ff; cfound = found_ff; hit = 1'b0;
      for (int d = 0; d < NumDeltas; d++) cd[d] = delta_ff[d];
      if (commit) begin
         for (int k = 0; k < NumNames; k++) begin
            if (!hit && cand_in[k] && pos_in == dir_len(k)) begin
               hit = 1'b1;
               cfound = 1'b1;
               if (k < NumFlags) begin
                  cf[k] = 1'b1;
               end else if (eq_in) begin
                  cd[k-NumFlags] = dseen_in ? {1'b0, acc_in} : DeltaAbsent;
               end else begin
                  cd[k-NumFlags] = (k == MaxStaleIx) ? DeltaNoValue : DeltaAbsent;
               end
            end
         end
      end

      // Start a fresh segment after a comma.
      if (is_comma) begin
         cand_in = '1; pos_in = '0; closed_in = 1'b0;
         eq_in = 1'b0; acc_in = '0; dseen_in = 1'b0; dend_in = 1'b0;
      end

      flags_in = cf; found_in = cfound;
      for (int d = 0; d < NumDeltas; d++) delta_in[d] = cd[d];

      rsp_in = '{cf, cd[0], cd[1], cd[2], cd[3], cd[4], cd[5], cfound};
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req.last_byte) begin
         rsp_valid_in = 1'b1;
         phase_in = PH_SKIP; cand_in = '1; pos_in = '0; closed_in = 1'b0;
         eq_in = 1'b0; acc_in = '0; dseen_in = 1'b0; dend_in = 1'b0;
         flags_in = '0; found_in = 1'b0;
         for (int d = 0; d < NumDeltas; d++) delta_in[d] = DeltaAbsent;
      end
   end

   // Hold state unless a transfer is taken; the result valid clears once read.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP; cand_ff <= '1; pos_ff <= '0; closed_ff <= 1'b0;
         eq_ff <= 1'b0; acc_ff <= '0; dseen_ff <= 1'b0; dend_ff <= 1'b0;
         flags_ff <= '0; found_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NumDeltas; d++) delta_ff[d] <= DeltaAbsent;
      end else begin
         if (take) begin
            phase_ff <= phase_in; cand_ff <= cand_in; pos_ff <= pos_in;
            closed_ff <= closed_in; eq_ff <= eq_in; acc_ff <= acc_in;
            dseen_ff <= dseen_in; dend_ff <= dend_in; flags_ff <= flags_in;
            found_ff <= found_in;
            for (int d = 0; d < NumDeltas; d++) delta_ff[d] <= delta_in[d];
            rsp_valid_ff <= rsp_valid_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Load the result register on the header's last byte.
   always_ff @(posedge clock) begin
      if (take && req.last_byte) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      !dseen_ff |-> acc_ff == '0) else $error("accumulator moved without digits");
   a_pos_name: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> pos_ff == '0 && cand_ff == '1)
      else $error("name state not clear while skipping");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result dropped under stall");
endmodule
